// ----- src/qlt_pkg.sv -----
// Shared types and constants for the quoted line tokenizer.
package qlt_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;

   localparam logic [CHAR_W-1:0] CH_HASH      = 8'h23;
   localparam logic [CHAR_W-1:0] CH_QUOTE     = 8'h22;
   localparam logic [CHAR_W-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [KIND_W-1:0] KIND_CHAR    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TOKEND  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LINEEND = 2'd2;

   typedef enum logic [5:0] {
      MODE_BETWEEN = 6'b000001,
      MODE_PLAIN   = 6'b000010,
      MODE_QUOTED  = 6'b000100,
      MODE_ESCAPE  = 6'b001000,
      MODE_DISCARD = 6'b010000,
      MODE_COMMENT = 6'b100000
   } qlt_mode_type;

   // Results caused by one item, in emission order: character, token end, line end.
   typedef struct packed {
      logic              has_char;
      logic              has_end;
      logic              has_line;
      logic [CHAR_W-1:0] char_code;
   } qlt_hits_type;

endpackage

// ----- src/qlt_scan.sv -----
// Scanner: tokenizer state and decoding of one character into its results.
module qlt_scan (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [qlt_pkg::CHAR_W-1:0]  char_code,
   input  logic                        line_end,
   output qlt_pkg::qlt_hits_type       hits
);
   import qlt_pkg::*;

   qlt_mode_type mode_ff, mode_in;
   logic         nonempty_ff, nonempty_in;
   logic         is_ws;

   assign is_ws = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);

   always_comb begin
      mode_in       = mode_ff;
      nonempty_in   = nonempty_ff;
      hits          = '0;
      hits.char_code = char_code;
      case (mode_ff)
         MODE_PLAIN: begin
            if (is_ws || (char_code == CH_HASH)) begin
               hits.has_end = 1'b1;
               mode_in      = (char_code == CH_HASH) ? MODE_COMMENT : MODE_BETWEEN;
               nonempty_in  = 1'b0;
            end else begin
               hits.has_char = 1'b1;
            end
         end
         MODE_QUOTED: begin
            if (char_code == CH_QUOTE) begin
               hits.has_end = nonempty_ff;
               nonempty_in  = 1'b0;
               mode_in      = MODE_DISCARD;
            end else if ((char_code == CH_BACKSLASH) && !line_end) begin
               mode_in = MODE_ESCAPE;
            end else begin
               hits.has_char = 1'b1;
               nonempty_in   = 1'b1;
            end
         end
         MODE_ESCAPE: begin
            hits.has_char = 1'b1;
            nonempty_in   = 1'b1;
            mode_in       = MODE_QUOTED;
         end
         MODE_DISCARD: begin
            if (is_ws) begin
               mode_in = MODE_BETWEEN;
            end else if (char_code == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end
         end
         MODE_COMMENT: begin
         end
         default: begin
            if (is_ws) begin
               mode_in = MODE_BETWEEN;
            end else if (char_code == CH_HASH) begin
               mode_in = MODE_COMMENT;
            end else if (char_code == CH_QUOTE) begin
               mode_in     = MODE_QUOTED;
               nonempty_in = 1'b0;
            end else begin
               hits.has_char = 1'b1;
               mode_in       = MODE_PLAIN;
               nonempty_in   = 1'b1;
            end
         end
      endcase

      // The line closes whatever token is open; an empty one gives no token end.
      if (line_end) begin
         if (((mode_in == MODE_PLAIN) || (mode_in == MODE_QUOTED) ||
              (mode_in == MODE_ESCAPE)) && nonempty_in) begin
            hits.has_end = 1'b1;
         end
         hits.has_line = 1'b1;
         mode_in       = MODE_BETWEEN;
         nonempty_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_BETWEEN;
         nonempty_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         nonempty_ff <= nonempty_in;
      end
   end

   a_line_resets: assert property (@(posedge clock) disable iff (reset)
      accept && line_end |=> (mode_ff == MODE_BETWEEN) && !nonempty_ff)
      else $error("state not cleared after a line end");

   a_comment_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (mode_ff == MODE_COMMENT) |-> !hits.has_char && !hits.has_end)
      else $error("comment produced token output");

endmodule

// ----- src/qlt_out.sv -----
// Result buffer: holds one item's results, handed out one per cycle unless stalled.
module qlt_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  qlt_pkg::qlt_hits_type       hits,
   output logic                        free,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,
   output logic [1:0]                  rsp_tuser,
   output logic                        rsp_tlast
);
   import qlt_pkg::*;

   logic              char_ff, end_ff, line_ff;
   logic              char_in, end_in, line_in;
   logic [CHAR_W-1:0] data_ff;
   logic              take;

   assign rsp_tvalid = char_ff | end_ff | line_ff;
   assign rsp_tlast  = ({char_ff, end_ff, line_ff} == 3'b100) ||
                       ({char_ff, end_ff, line_ff} == 3'b010) ||
                       ({char_ff, end_ff, line_ff} == 3'b001);
   assign rsp_tuser  = char_ff ? KIND_CHAR : (end_ff ? KIND_TOKEND : KIND_LINEEND);
   assign rsp_tdata  = char_ff ? data_ff : '0;
   assign take       = rsp_tvalid && rsp_tready;
   assign free       = !rsp_tvalid || (take && rsp_tlast);

   always_comb begin
      char_in = char_ff;
      end_in  = end_ff;
      line_in = line_ff;
      if (load) begin
         char_in = hits.has_char;
         end_in  = hits.has_end;
         line_in = hits.has_line;
      end else if (take) begin
         // Retire the result now on the port: the first flag still set.
         if (char_ff) begin
            char_in = 1'b0;
         end else if (end_ff) begin
            end_in = 1'b0;
         end else begin
            line_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= 1'b0;
         end_ff  <= 1'b0;
         line_ff <= 1'b0;
      end else begin
         char_ff <= char_in;
         end_ff  <= end_in;
         line_ff <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= hits.char_code;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("result buffer loaded while results remain");

   a_line_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_LINEEND) |-> rsp_tlast)
      else $error("line end not marked as final result");

   a_kind_defined: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_CHAR) || (rsp_tuser == KIND_TOKEND) ||
                     (rsp_tuser == KIND_LINEEND))
      else $error("undefined result kind");

endmodule

// ----- src/quoted_line_tokenizer.sv -----
// Top level of the quoted line tokenizer: scanner and result buffer.
//
//   channel  direction  tdata                  tuser        tlast
//   req_     in         [7:0] char_code        -            line_end
//   rsp_     out        [7:0] token_char       [1:0] kind   last
//
// Each character is decoded in the cycle it is accepted and its results
// (up to three: a character, a token end, a line end) land in the result
// buffer, which hands out one result per cycle while rsp_tready is high.
// The next item is taken in the cycle the buffer's final result leaves.
// Reset is synchronous and active high; it empties the buffer and puts the
// scanner between tokens. A stall on rsp_tready holds the current result.
module quoted_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // line_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_char
   output logic [1:0] rsp_tuser,   // [1:0] kind
   output logic       rsp_tlast    // last
);
   import qlt_pkg::*;

   qlt_hits_type hits;
   logic         free;
   logic         accept;

   // An item enters whenever the buffer is empty or is giving up its final result.
   assign req_tready = free;
   assign accept     = req_tvalid && free;

   qlt_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_code (req_tdata),
      .line_end  (req_tlast),
      .hits      (hits)
   );

   qlt_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (accept),
      .hits       (hits),
      .free       (free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- test/tb_quoted_line_tokenizer.sv -----
// Self-checking testbench for the quoted line tokenizer, with its own prediction of the results.
module tb_quoted_line_tokenizer;
   import qlt_pkg::*;

   // One result item as the block hands it out on the rsp_ channel.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] token_char;
      logic              last;
   } token_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_code
   logic       req_tlast = 1'b0;    // line_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] token_char
   logic [1:0] rsp_tuser;           // [1:0] kind
   logic       rsp_tlast;           // last

   quoted_line_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // Predicted scanner state, kept in step with every accepted item.
   qlt_mode_type     scan_state = MODE_BETWEEN;
   logic             token_has_chars = 1'b0;
   token_result_type pending_tokens[$];

   // Idling percentages for each side, and a one-off long stall of the receiver.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_len = 0;
   int unsigned stall_seq = 0;
   int unsigned stall_seen = 0;
   int unsigned stall_left = 0;

   int unsigned mismatches = 0;
   int unsigned items_sent = 0;
   int unsigned lines_sent = 0;
   int unsigned results_checked = 0;
   token_result_type got_result;
   token_result_type want_result;

   function automatic logic is_blank(input logic [7:0] c);
      return (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;
   endfunction

   function automatic token_result_type make_result(input logic [KIND_W-1:0] kind,
                                                    input logic [CHAR_W-1:0] ch);
      token_result_type r;
      r.kind       = kind;
      r.token_char = ch;
      r.last       = 1'b0;
      return r;
   endfunction

   // Works out the results of one accepted item: an optional character, an optional
   // token end and, on the last byte of a line, a line end. The final one carries last.
   task automatic predict_tokens(input logic [7:0] c, input logic eol);
      token_result_type batch[$];
      case (scan_state)
         MODE_PLAIN: begin
            if (is_blank(c) || c == CH_HASH) begin
               batch.insert(batch.size(), make_result(KIND_TOKEND, 8'h00));
               if (c == CH_HASH) scan_state = MODE_COMMENT;
               else scan_state = MODE_BETWEEN;
               token_has_chars = 1'b0;
            end else begin
               batch.insert(batch.size(), make_result(KIND_CHAR, c));
            end
         end
         MODE_QUOTED: begin
            if (c == CH_QUOTE) begin
               // A closing quote ends the token; an empty pair gives nothing.
               if (token_has_chars) batch.insert(batch.size(), make_result(KIND_TOKEND, 8'h00));
               token_has_chars = 1'b0;
               scan_state = MODE_DISCARD;
            end else if (c == CH_BACKSLASH && !eol) begin
               scan_state = MODE_ESCAPE;
            end else begin
               // A backslash on the last byte of the line is kept as a character.
               batch.insert(batch.size(), make_result(KIND_CHAR, c));
               token_has_chars = 1'b1;
            end
         end
         MODE_ESCAPE: begin
            batch.insert(batch.size(), make_result(KIND_CHAR, c));
            token_has_chars = 1'b1;
            scan_state = MODE_QUOTED;
         end
         MODE_DISCARD: begin
            if (is_blank(c)) scan_state = MODE_BETWEEN;
            else if (c == CH_HASH) scan_state = MODE_COMMENT;
         end
         MODE_COMMENT: begin
         end
         default: begin
            if (is_blank(c)) begin
               scan_state = MODE_BETWEEN;
            end else if (c == CH_HASH) begin
               scan_state = MODE_COMMENT;
            end else if (c == CH_QUOTE) begin
               scan_state = MODE_QUOTED;
               token_has_chars = 1'b0;
            end else begin
               batch.insert(batch.size(), make_result(KIND_CHAR, c));
               scan_state = MODE_PLAIN;
               token_has_chars = 1'b1;
            end
         end
      endcase
      if (eol) begin
         // An open token, quoted or not, closes at the end of the line.
         if ((scan_state == MODE_PLAIN || scan_state == MODE_QUOTED ||
              scan_state == MODE_ESCAPE) && token_has_chars)
            batch.insert(batch.size(), make_result(KIND_TOKEND, 8'h00));
         batch.insert(batch.size(), make_result(KIND_LINEEND, 8'h00));
         scan_state = MODE_BETWEEN;
         token_has_chars = 1'b0;
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) pending_tokens.insert(pending_tokens.size(), batch[i]);
   endtask

   // Offers one byte, with random gaps before it, and waits for the handshake. The
   // ready is read at the falling edge, where it has settled for the coming rising edge.
   task automatic send_item(input logic [7:0] c, input logic eol);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eol;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      predict_tokens(c, eol);
      items_sent++;
      if (eol) lines_sent++;
   endtask

   task automatic send_text(input string s, input logic eol_on_last);
      for (int i = 0; i < s.len(); i++)
         send_item(s[i], eol_on_last && (i == s.len() - 1));
   endtask

   // Drops the valid and waits until every predicted result has come out.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_tokens.size() != 0) @(posedge clock);
   endtask

   // Bytes weighted towards the characters that steer the scanner, with a share of
   // arbitrary byte values so that every bit of the field is exercised.
   function automatic logic [7:0] random_char();
      int unsigned pick;
      int unsigned blank;
      pick = $urandom_range(99);
      if (pick < 35) return 8'($urandom_range(8'h61, 8'h7A));
      if (pick < 50) begin
         blank = $urandom_range(5);
         if (blank == 5) return CH_SPACE;
         return CH_TAB + 8'(blank);
      end
      if (pick < 60) return CH_QUOTE;
      if (pick < 68) return CH_BACKSLASH;
      if (pick < 73) return CH_HASH;
      return 8'($urandom_range(255));
   endfunction

   // Hand-written lines that reach each special case and end a line in most states.
   task automatic test_special_cases();
      send_text("ab#c", 1'b1);            // hash ends a plain token, line ends in a comment
      send_text("\"\"x#", 1'b0);          // empty quotes, bytes stuck to the quote, then a hash
      send_item(8'hFF, 1'b1);
      send_text("\"", 1'b1);              // unterminated quote with nothing inside
      send_text("\"\\", 1'b1);            // backslash as the line's last byte inside quotes
      send_text("\"\\\"", 1'b1);          // line ends right after an escaped quote
      send_item(8'h00, 1'b0);             // lowest and highest byte values as token characters
      send_item(8'hFF, 1'b0);
      for (int c = 9; c <= 13; c++) send_item(8'(c), 1'b0);
      send_item(CH_SPACE, 1'b1);          // line ends between tokens
      send_text("\"a", 1'b1);             // unterminated quote that has a character
      settle();
   endtask

   task automatic test_random_lines(input int unsigned count);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < count) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
         for (int i = 0; i < len; i++) send_item(random_char(), i == len - 1);
         sent += len;
      end
      settle();
   endtask

   // The receiver stops for a long while as the sender keeps offering bytes, so that
   // the result buffer fills up and the input stalls.
   task automatic test_output_stall();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_len = 120;
      stall_seq++;
      send_text("alpha \"be ta\\\"\" gamma#x", 1'b1);
      settle();
   endtask

   // Receiver: random idling, overridden by a requested long stall.
   always @(posedge clock) begin
      if (stall_seq != stall_seen) begin
         stall_seen = stall_seq;
         stall_left = stall_len;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input token_result_type want,
                                  input token_result_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: expected kind %0d char %02h last %0b, got kind %0d char %02h last %0b",
                  what, want.kind, want.token_char, want.last,
                  got.kind, got.token_char, got.last);
   endtask

   // Result check, sampled at the falling edge ahead of the rising edge that takes it.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_result = '{rsp_tuser, rsp_tdata, rsp_tlast};
         results_checked++;
         if (pending_tokens.size() == 0) begin
            report_mismatch("unexpected result", '0, got_result);
         end else begin
            want_result = pending_tokens.pop_front();
            if (got_result.kind !== want_result.kind ||
                got_result.token_char !== want_result.token_char ||
                got_result.last !== want_result.last)
               report_mismatch("wrong result", want_result, got_result);
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 82;
      test_special_cases();
      test_random_lines(60);

      send_idle_pct = 82;
      recv_idle_pct = 35;
      test_random_lines(60);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_lines(60);

      test_output_stall();

      repeat (20) @(posedge clock);
      if (pending_tokens.size() != 0) begin
         $display("%0d expected results never arrived", pending_tokens.size());
         mismatches += pending_tokens.size();
      end
      $display("Run covered %0d bytes in %0d lines and checked %0d results,", items_sent,
               lines_sent, results_checked);
      $display("with quotes, escapes, comments, three idling mixes and a long output stall.");
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest correct run.
   initial begin
      #3000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
src/qlt_pkg.sv
src/qlt_scan.sv
src/qlt_out.sv
src/quoted_line_tokenizer.sv
test/tb_quoted_line_tokenizer.sv
